/* rtl/core/spr_eval_pkg.sv */
`default_nettype none

package spr_eval_pkg;

	localparam int PRIMARY_BYTES   = 256;
	localparam int SECONDARY_BYTES = 32;
	localparam int PADDR_W         = $clog2(PRIMARY_BYTES);
	localparam int SIDX_W          = $clog2(SECONDARY_BYTES);
	localparam int PPTR_W          = 9;
	localparam int SPTR_W          = 6;

	localparam logic [PPTR_W-1:0] PPTR_END     = 9'h101;
	localparam logic [PPTR_W-1:0] PPTR_ZERO    = 9'h001;
	localparam logic [PPTR_W-1:0] PPTR_DIAG    = 9'h020;
	localparam logic [SPTR_W-1:0] SPTR_OVF     = 6'h21;
	localparam logic [9:0]        HEIGHT_SHORT = 10'h008;
	localparam logic [9:0]        HEIGHT_TALL  = 10'h010;

	typedef enum logic [1:0] {
		FUNC_EVAL      = 2'd0,
		FUNC_WRITE     = 2'd1,
		FUNC_RESTART   = 2'd2,
		FUNC_CLEAR_OVF = 2'd3
	} func_t;

	typedef struct packed {
		func_t       func;
		logic        odd_dot;
		logic        render_enable;
		logic        tall_sprites;
		logic [8:0]  scanline;
		logic [7:0]  table_addr;
		logic [7:0]  table_value;
	} item_t;

	typedef struct packed {
		logic              secondary_write;
		logic [SIDX_W-1:0] secondary_index;
		logic [7:0]        secondary_value;
		logic [7:0]        latched_byte;
		logic              overflow_flag;
		logic              sprite_zero_hit_line;
	} result_t;

endpackage

`default_nettype wire

/* rtl/core/spr_eval_if.sv */
`default_nettype none

interface spr_eval_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic       odd_dot;
	logic       render_enable;
	logic       tall_sprites;
	logic [8:0] scanline;
	logic [7:0] table_addr;
	logic [7:0] table_value;

	modport source (output valid, func, odd_dot, render_enable, tall_sprites,
		scanline, table_addr, table_value, input ready);
	modport sink (input valid, func, odd_dot, render_enable, tall_sprites,
		scanline, table_addr, table_value, output ready);
endinterface

interface spr_eval_out_if;
	logic       valid;
	logic       ready;
	logic       secondary_write;
	logic [4:0] secondary_index;
	logic [7:0] secondary_value;
	logic [7:0] latched_byte;
	logic       overflow_flag;
	logic       sprite_zero_hit_line;

	modport source (output valid, secondary_write, secondary_index, secondary_value,
		latched_byte, overflow_flag, sprite_zero_hit_line, input ready);
	modport sink (input valid, secondary_write, secondary_index, secondary_value,
		latched_byte, overflow_flag, sprite_zero_hit_line, output ready);
endinterface

`default_nettype wire

/* rtl/core/spr_eval_core.sv */
`default_nettype none

module spr_eval_core (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   accept,
	input  wire spr_eval_pkg::item_t    item,
	output logic                        res_valid,
	output spr_eval_pkg::result_t       res
);

	localparam int PADDR_W = spr_eval_pkg::PADDR_W;
	localparam int PPTR_W  = spr_eval_pkg::PPTR_W;
	localparam int SPTR_W  = spr_eval_pkg::SPTR_W;
	localparam int SIDX_W  = spr_eval_pkg::SIDX_W;

	logic [7:0] ptable [spr_eval_pkg::PRIMARY_BYTES];

	logic [7:0]        latch_q;
	logic [PPTR_W-1:0] pptr_q, pptr_d;
	logic [SPTR_W-1:0] sptr_q, sptr_d;
	logic [1:0]        cd_q, cd_d;
	logic              ovf_q, ovf_d;
	logic              sz_q, sz_d;

	logic              rd_en;
	logic              wr_en;
	logic              sec_wr;
	logic              wr_s1;
	logic [SIDX_W-1:0] idx_s1;
	logic [7:0]        val_s1;
	logic              valid_s1;

	logic [9:0]        y_ext, y_end, line_ext;
	logic              hit;
	logic [SPTR_W-1:0] sptr_inc;
	logic [PPTR_W-1:0] p_dec, p_diag;

	logic is_eval;

	assign is_eval  = item.func == spr_eval_pkg::FUNC_EVAL && item.render_enable;
	assign y_ext    = {2'b00, latch_q};
	assign y_end    = y_ext + (item.tall_sprites ? spr_eval_pkg::HEIGHT_TALL
		: spr_eval_pkg::HEIGHT_SHORT);
	assign line_ext = {1'b0, item.scanline};
	assign hit      = line_ext >= y_ext && line_ext < y_end;
	assign sptr_inc = sptr_q + SPTR_W'(1);
	// next sprite, next byte within it
	assign p_dec    = pptr_q - PPTR_W'(1);
	assign p_diag   = {p_dec[PPTR_W-1:2] + (PPTR_W-2)'(1), p_dec[1:0] + 2'd1};

	always_comb begin
		pptr_d = pptr_q;
		sptr_d = sptr_q;
		cd_d   = cd_q;
		ovf_d  = ovf_q;
		sz_d   = sz_q;
		rd_en  = 1'b0;
		wr_en  = 1'b0;
		sec_wr = 1'b0;
		unique case (item.func)
			spr_eval_pkg::FUNC_EVAL: begin
				if (!item.render_enable) begin
					// disabled rendering: hold everything
				end else if (item.odd_dot) begin
					rd_en  = 1'b1;
					pptr_d = pptr_q + PPTR_W'(1);
					if (sptr_q == spr_eval_pkg::SPTR_OVF) begin
						ovf_d = 1'b1;
					end
				end else if (pptr_q < spr_eval_pkg::PPTR_END) begin
					sec_wr = !sptr_q[SPTR_W-1];
					if (cd_q == 2'd0) begin
						if (pptr_q == spr_eval_pkg::PPTR_ZERO) begin
							sz_d = hit;
						end
						if (hit) begin
							sptr_d = sptr_inc;
							cd_d   = 2'd3;
							if (sptr_inc >= SPTR_W'(spr_eval_pkg::SECONDARY_BYTES)) begin
								pptr_d = pptr_q + PPTR_W'(3);
							end
						end else if (sptr_q >= SPTR_W'(spr_eval_pkg::SECONDARY_BYTES)
							&& pptr_q >= spr_eval_pkg::PPTR_DIAG) begin
							pptr_d = p_diag;
						end else begin
							pptr_d = pptr_q + PPTR_W'(3);
						end
					end else begin
						sptr_d = sptr_inc;
						cd_d   = cd_q - 2'd1;
					end
				end
			end
			spr_eval_pkg::FUNC_WRITE: begin
				wr_en = 1'b1;
			end
			spr_eval_pkg::FUNC_RESTART: begin
				pptr_d = '0;
				sptr_d = '0;
				cd_d   = '0;
			end
			spr_eval_pkg::FUNC_CLEAR_OVF: begin
				ovf_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			ptable[item.table_addr] <= item.table_value;
		end
	end

	// registered read port doubles as the read latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q <= '0;
		end else if (accept && rd_en) begin
			latch_q <= ptable[pptr_q[PADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pptr_q   <= '0;
			sptr_q   <= '0;
			cd_q     <= '0;
			ovf_q    <= 1'b0;
			sz_q     <= 1'b0;
			valid_s1 <= 1'b0;
			wr_s1    <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				pptr_q <= pptr_d;
				sptr_q <= sptr_d;
				cd_q   <= cd_d;
				ovf_q  <= ovf_d;
				sz_q   <= sz_d;
				wr_s1  <= is_eval && sec_wr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1 <= (is_eval && sec_wr) ? sptr_q[SIDX_W-1:0] : '0;
			val_s1 <= (is_eval && sec_wr) ? latch_q : '0;
		end
	end

	assign res_valid                = valid_s1;
	assign res.secondary_write      = wr_s1;
	assign res.secondary_index      = idx_s1;
	assign res.secondary_value      = val_s1;
	assign res.latched_byte         = latch_q;
	assign res.overflow_flag        = ovf_q;
	assign res.sprite_zero_hit_line = sz_q;

endmodule

`default_nettype wire

/* rtl/core/spr_eval_outq.sv */
`default_nettype none

module spr_eval_outq (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire spr_eval_pkg::result_t push_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output spr_eval_pkg::result_t      out_data,
	output logic [1:0]                 count
);

	localparam logic [1:0] LAST = 2'd2;

	spr_eval_pkg::result_t entry_q [3];
	logic [1:0] wptr_q, rptr_q, cnt_q;
	logic       pop;

	assign out_valid = cnt_q != 2'd0;
	assign pop       = out_valid && out_ready;
	assign out_data  = entry_q[rptr_q];
	assign count     = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == LAST) ? 2'd0 : wptr_q + 2'd1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == LAST) ? 2'd0 : rptr_q + 2'd1;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

`default_nettype wire

/* rtl/core/sprite_evaluation_step.sv */
// Sprite evaluation step, one item per picture unit dot.
// Channel dot (sink): func selects an evaluation dot, a primary table byte
// write, a restart of the evaluation pointers or a clear of the overflow
// bit; the other fields carry the dot's phase, mode, scanline and write data.
// Channel result (source): one item per accepted dot, in order, with the
// secondary table write made on that dot and the latch, overflow and sprite
// zero status after it.
// Throughput: one item per cycle while dot.ready is high. The 256-byte
// primary table is a synchronous memory whose registered read port is the
// read latch; an even dot compares that latch and steers the pointer for
// the next odd dot's read in the same cycle, so the read-compare loop
// closes every two dots. A result passes through the evaluation register
// and then a three-entry result queue before it is offered.
// Stall: while the receiver holds ready low the queue fills and dot.ready
// drops once queue plus evaluation register hold three items; no item is
// lost. Reset clears pointers, flags, latch and queue; the primary table
// holds no reset value and must be written before it is read.
`default_nettype none

module sprite_evaluation_step (
	input  wire logic      clk,
	input  wire logic      arst_n,
	spr_eval_in_if.sink    dot,
	spr_eval_out_if.source result
);

	spr_eval_pkg::item_t   item;
	spr_eval_pkg::result_t res, res_out;
	logic                  res_valid;
	logic                  accept;
	logic [1:0]            q_count;

	assign item.func          = spr_eval_pkg::func_t'(dot.func);
	assign item.odd_dot       = dot.odd_dot;
	assign item.render_enable = dot.render_enable;
	assign item.tall_sprites  = dot.tall_sprites;
	assign item.scanline      = dot.scanline;
	assign item.table_addr    = dot.table_addr;
	assign item.table_value   = dot.table_value;

	// room for this item once everything already in flight is queued
	assign dot.ready = ({1'b0, q_count} + {2'b00, res_valid}) <= 3'd2;
	assign accept    = dot.valid && dot.ready;

	spr_eval_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.res_valid (res_valid),
		.res       (res)
	);

	spr_eval_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (res_out),
		.count     (q_count)
	);

	assign result.secondary_write      = res_out.secondary_write;
	assign result.secondary_index      = res_out.secondary_index;
	assign result.secondary_value      = res_out.secondary_value;
	assign result.latched_byte         = res_out.latched_byte;
	assign result.overflow_flag        = res_out.overflow_flag;
	assign result.sprite_zero_hit_line = res_out.sprite_zero_hit_line;

endmodule

`default_nettype wire
